### src/edr_pkg.sv
// package for the euclidean distance block: widths, operation codes and
// the data type handed along the square root cell chain
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package edr_pkg;

	// point geometry
	localparam int DIMENSION = 10;
	localparam int COORD_WIDTH = 7;
	localparam int NUM_COORD_FIELDS = 10;

	// result widths and fixed point format
	localparam int SQ_WIDTH = 18;
	localparam int DIST_WIDTH = 17;
	localparam int FRAC_BITS = 8;

	// squared difference of one coordinate and the sum of a pair of them
	localparam int SQD_WIDTH = 2 * COORD_WIDTH;
	localparam int PAIR_WIDTH = SQD_WIDTH + 1;
	localparam int PAIRS = (DIMENSION + 1) / 2;

	// square root datapath
	localparam int RAD_WIDTH = 2 * DIST_WIDTH;
	localparam int REM_WIDTH = DIST_WIDTH + 1;
	localparam int WORK_WIDTH = REM_WIDTH + 2;
	localparam int ROOT_CELLS = DIST_WIDTH;

	// operation codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_MEASURE = 1'b1;

	// one request in flight along the root chain
	typedef struct packed {
		logic [RAD_WIDTH-1:0] rad;
		logic [REM_WIDTH-1:0] rem;
		logic [DIST_WIDTH-1:0] root;
		logic [SQ_WIDTH-1:0] sq;
	} root_data_t;

endpackage

`default_nettype wire

### src/edr_lane.sv
// one coordinate lane: holds a reference coordinate and squares the
// distance of an incoming coordinate to it; uses edr_pkg
`timescale 1ns / 1ps
`default_nettype none

module edr_lane
	import edr_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [COORD_WIDTH-1:0] coord,
	input wire logic load,
	input wire logic take,
	output logic [SQD_WIDTH-1:0] sq_s1
);

	logic [COORD_WIDTH-1:0] ref_q;
	logic [COORD_WIDTH-1:0] diff;
	logic [SQD_WIDTH-1:0] sq;

	// absolute difference and its square
	always_comb begin
		if (coord >= ref_q) begin
			diff = coord - ref_q;
		end else begin
			diff = ref_q - coord;
		end
		sq = SQD_WIDTH'(diff) * SQD_WIDTH'(diff);
	end

	// reference coordinate, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= '0;
		end else if (load) begin
			ref_q <= coord;
		end
	end

	// squared difference register
	always_ff @(posedge clk) begin
		if (take) begin
			sq_s1 <= sq;
		end
	end

endmodule

`default_nettype wire

### src/edr_root_cell.sv
// one cell of the square root chain: settles one result bit per request
// and hands the partial root and remainder to the next cell; uses edr_pkg
`timescale 1ns / 1ps
`default_nettype none

module edr_root_cell
	import edr_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic up_valid,
	output logic up_ready,
	input wire root_data_t up_data,
	output logic dn_valid,
	input wire logic dn_ready,
	output root_data_t dn_data
);

	logic valid_q;
	root_data_t data_q;
	root_data_t next;
	logic [WORK_WIDTH-1:0] cur;
	logic [WORK_WIDTH-1:0] trial;

	// restoring root step: bring down two radicand bits, try root*4+1
	always_comb begin
		cur = {up_data.rem, up_data.rad[RAD_WIDTH-1 -: 2]};
		trial = {1'b0, up_data.root, 2'b01};
		next.rad = {up_data.rad[RAD_WIDTH-3:0], 2'b00};
		next.sq = up_data.sq;
		if (cur >= trial) begin
			next.rem = REM_WIDTH'(cur - trial);
			next.root = {up_data.root[DIST_WIDTH-2:0], 1'b1};
		end else begin
			next.rem = cur[REM_WIDTH-1:0];
			next.root = {up_data.root[DIST_WIDTH-2:0], 1'b0};
		end
	end

	// cell takes a new request when empty or when its own moves on
	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= next;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data = data_q;

endmodule

`default_nettype wire

### src/euclidean_distance_to_reference.sv
// an accepted measure request passes the lane square register, two adder
// stages and 17 root cells, one result bit per cell, to result_valid
// throughput: one request per cycle; every stage stalls only when full
// load requests update the reference at acceptance and give no result
// reset clears the reference point and all valid flags; no clearing pass
// uses edr_pkg, edr_lane, edr_root_cell
`timescale 1ns / 1ps
`default_nettype none

module euclidean_distance_to_reference
	import edr_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_ready,
	input wire logic operation,
	input wire logic [COORD_WIDTH-1:0] coord_0,
	input wire logic [COORD_WIDTH-1:0] coord_1,
	input wire logic [COORD_WIDTH-1:0] coord_2,
	input wire logic [COORD_WIDTH-1:0] coord_3,
	input wire logic [COORD_WIDTH-1:0] coord_4,
	input wire logic [COORD_WIDTH-1:0] coord_5,
	input wire logic [COORD_WIDTH-1:0] coord_6,
	input wire logic [COORD_WIDTH-1:0] coord_7,
	input wire logic [COORD_WIDTH-1:0] coord_8,
	input wire logic [COORD_WIDTH-1:0] coord_9,
	output logic result_valid,
	input wire logic result_ready,
	output logic [SQ_WIDTH-1:0] squared_distance,
	output logic [DIST_WIDTH-1:0] distance_fixed
);

	logic [COORD_WIDTH-1:0] coord_a [NUM_COORD_FIELDS];
	logic [SQD_WIDTH-1:0] sq_s1 [DIMENSION];
	logic [PAIR_WIDTH-1:0] pair_s2 [PAIRS];
	logic [SQ_WIDTH-1:0] sum_s3;
	logic [SQ_WIDTH-1:0] sum_comb;
	logic v_s1, v_s2, v_s3;
	logic s1_ready, s2_ready, s3_ready;
	logic accept, load, take;

	logic root_valid [ROOT_CELLS+1];
	logic root_ready [ROOT_CELLS+1];
	root_data_t root_data [ROOT_CELLS+1];

	assign coord_a[0] = coord_0;
	assign coord_a[1] = coord_1;
	assign coord_a[2] = coord_2;
	assign coord_a[3] = coord_3;
	assign coord_a[4] = coord_4;
	assign coord_a[5] = coord_5;
	assign coord_a[6] = coord_6;
	assign coord_a[7] = coord_7;
	assign coord_a[8] = coord_8;
	assign coord_a[9] = coord_9;

	// request handshake and stage stall chain
	assign s3_ready = !v_s3 || root_ready[0];
	assign s2_ready = !v_s2 || s3_ready;
	assign s1_ready = !v_s1 || s2_ready;
	assign item_ready = s1_ready;
	assign accept = item_valid && item_ready;
	assign load = accept && (operation == OP_LOAD);
	assign take = accept && (operation == OP_MEASURE);

	// coordinate lanes
	for (genvar k = 0; k < DIMENSION; k++) begin : g_lane
		edr_lane u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.coord(coord_a[k]),
			.load(load),
			.take(take),
			.sq_s1(sq_s1[k])
		);
	end

	// valid flags of the lane and adder stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (s1_ready) begin
				v_s1 <= take;
			end
			if (s2_ready) begin
				v_s2 <= v_s1;
			end
			if (s3_ready) begin
				v_s3 <= v_s2;
			end
		end
	end

	// first adder stage: pairs of lane squares
	for (genvar p = 0; p < PAIRS; p++) begin : g_pair
		if (2 * p + 1 < DIMENSION) begin : g_two
			always_ff @(posedge clk) begin
				if (s2_ready && v_s1) begin
					pair_s2[p] <= PAIR_WIDTH'(sq_s1[2*p]) + PAIR_WIDTH'(sq_s1[2*p+1]);
				end
			end
		end else begin : g_one
			always_ff @(posedge clk) begin
				if (s2_ready && v_s1) begin
					pair_s2[p] <= PAIR_WIDTH'(sq_s1[2*p]);
				end
			end
		end
	end

	// second adder stage: total of the pair sums
	always_comb begin
		sum_comb = '0;
		for (int p = 0; p < PAIRS; p++) begin
			sum_comb = sum_comb + SQ_WIDTH'(pair_s2[p]);
		end
	end

	always_ff @(posedge clk) begin
		if (s3_ready && v_s2) begin
			sum_s3 <= sum_comb;
		end
	end

	// radicand is the sum scaled by two fraction widths
	assign root_valid[0] = v_s3;
	assign root_data[0].rad = {sum_s3, {(2*FRAC_BITS){1'b0}}};
	assign root_data[0].rem = '0;
	assign root_data[0].root = '0;
	assign root_data[0].sq = sum_s3;

	// square root cell chain, the last cell is the output register
	for (genvar i = 0; i < ROOT_CELLS; i++) begin : g_root
		edr_root_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.up_valid(root_valid[i]),
			.up_ready(root_ready[i]),
			.up_data(root_data[i]),
			.dn_valid(root_valid[i+1]),
			.dn_ready(root_ready[i+1]),
			.dn_data(root_data[i+1])
		);
	end

	assign root_ready[ROOT_CELLS] = result_ready;
	assign result_valid = root_valid[ROOT_CELLS];
	assign squared_distance = root_data[ROOT_CELLS].sq;
	assign distance_fixed = root_data[ROOT_CELLS].root;

	// root bounds for checking
	logic [RAD_WIDTH+1:0] chk_rad;
	logic [RAD_WIDTH+1:0] chk_lo;
	logic [RAD_WIDTH+1:0] chk_hi;

	always_comb begin
		chk_rad = {2'b00, squared_distance, {(2*FRAC_BITS){1'b0}}};
		chk_lo = (RAD_WIDTH+2)'(distance_fixed) * (RAD_WIDTH+2)'(distance_fixed);
		chk_hi = ((RAD_WIDTH+2)'(distance_fixed) + 1'b1)
			* ((RAD_WIDTH+2)'(distance_fixed) + 1'b1);
	end

	// root is never above the exact root
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (chk_lo <= chk_rad))
		else $error("distance_fixed squared exceeds scaled squared_distance");

	// root plus one is always above the exact root
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (chk_hi > chk_rad))
		else $error("distance_fixed is not the floor of the root");

	// a load request never enters the datapath
	assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && (operation == OP_LOAD)) |=> !v_s1)
		else $error("load request produced a pipeline entry");

endmodule

`default_nettype wire

### tb/sv/euclidean_distance_to_reference_test.sv
`timescale 1ns / 1ps
// testbench for euclidean_distance_to_reference: directed and random points, each distance
// predicted at request acceptance and checked in order against the returned results
// depends on edr_pkg and the block's sources

module euclidean_distance_to_reference_test
	import edr_pkg::*;
();

	typedef logic [NUM_COORD_FIELDS-1:0][COORD_WIDTH-1:0] point_t;

	typedef struct packed {
		logic op;
		point_t coord;
	} point_req_t;

	typedef struct packed {
		logic [SQ_WIDTH-1:0] sq;
		logic [DIST_WIDTH-1:0] root;
	} distance_t;

	localparam int COORD_MAX = (1 << COORD_WIDTH) - 1;
	localparam int RANDOM_ITEMS = 1700;
	localparam int MAX_GAP = 8;
	localparam int HOLD_START = 400;
	localparam int HOLD_CYCLES = 200;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_PRINTS = 50;
	localparam real TIMEOUT_NS = 1000000.0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	logic operation = OP_LOAD;
	logic [COORD_WIDTH-1:0] coord_0 = '0;
	logic [COORD_WIDTH-1:0] coord_1 = '0;
	logic [COORD_WIDTH-1:0] coord_2 = '0;
	logic [COORD_WIDTH-1:0] coord_3 = '0;
	logic [COORD_WIDTH-1:0] coord_4 = '0;
	logic [COORD_WIDTH-1:0] coord_5 = '0;
	logic [COORD_WIDTH-1:0] coord_6 = '0;
	logic [COORD_WIDTH-1:0] coord_7 = '0;
	logic [COORD_WIDTH-1:0] coord_8 = '0;
	logic [COORD_WIDTH-1:0] coord_9 = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic [SQ_WIDTH-1:0] squared_distance;
	logic [DIST_WIDTH-1:0] distance_fixed;

	point_req_t pending_points[$];
	distance_t distance_expected[$];
	point_t reference_copy = '0;
	point_t generated_reference = '0;
	point_req_t offered;
	int total_items = 0;
	int sent_count = 0;
	int accepted_count = 0;
	int result_count = 0;
	int error_count = 0;
	int send_gap = 0;
	int recv_gap = 0;
	logic hold_results = 1'b0;

	euclidean_distance_to_reference DUT (.*);

	// clock and reset
	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// floor of sqrt(sq * 2^(2*FRAC_BITS)), one root bit per step from the top
	function automatic logic [DIST_WIDTH-1:0] fixed_root(logic [SQ_WIDTH-1:0] sq);
		longint unsigned radicand;
		longint unsigned trial;
		logic [DIST_WIDTH-1:0] root;
		radicand = longint'(sq) << (2 * FRAC_BITS);
		root = '0;
		for (int b = DIST_WIDTH - 1; b >= 0; b--) begin
			trial = longint'(root) | (64'd1 << b);
			if (trial * trial <= radicand)
				root[b] = 1'b1;
		end
		return root;
	endfunction

	function automatic distance_t predict_distance(point_t p, point_t r);
		distance_t d;
		int sum;
		int diff;
		sum = 0;
		for (int k = 0; k < DIMENSION; k++) begin
			diff = int'(p[k]) - int'(r[k]);
			sum += diff * diff;
		end
		d.sq = sum[SQ_WIDTH-1:0];
		d.root = fixed_root(d.sq);
		return d;
	endfunction

	function automatic point_t all_coords(int v);
		point_t p;
		for (int k = 0; k < NUM_COORD_FIELDS; k++)
			p[k] = v[COORD_WIDTH-1:0];
		return p;
	endfunction

	// style 0 and 3 uniform, 1 extremes, 2 close to the current reference
	function automatic logic [COORD_WIDTH-1:0] random_coord(int style, int near);
		int v;
		case (style)
			1: begin
				v = $urandom_range(0, 1) ? COORD_MAX : 0;
			end
			2: begin
				v = near + int'($urandom_range(0, 6)) - 3;
				if (v < 0)
					v = 0;
				if (v > COORD_MAX)
					v = COORD_MAX;
			end
			default: begin
				v = $urandom_range(0, COORD_MAX);
			end
		endcase
		return v[COORD_WIDTH-1:0];
	endfunction

	task automatic add_request(logic op, point_t p);
		point_req_t r;
		r.op = op;
		r.coord = p;
		pending_points.push_back(r);
		total_items++;
		if (op == OP_LOAD)
			generated_reference = p;
	endtask

	task automatic report_mismatch(string what, longint want, longint got);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("mismatch at result %0d: %s expected %0d got %0d",
				result_count, what, want, got);
	endtask

	// stimulus: directed corners first, then random points
	initial begin
		point_t p;
		int kind;
		int style;

		// reference is zero after reset
		add_request(OP_MEASURE, all_coords(0));
		add_request(OP_MEASURE, all_coords(COORD_MAX));
		// largest distance from the opposite corner, zero from itself
		add_request(OP_LOAD, all_coords(COORD_MAX));
		add_request(OP_MEASURE, all_coords(0));
		add_request(OP_MEASURE, all_coords(COORD_MAX));
		// alternating corner and its complement
		for (int k = 0; k < NUM_COORD_FIELDS; k++)
			p[k] = COORD_WIDTH'((k % 2) ? COORD_MAX : 0);
		add_request(OP_LOAD, p);
		add_request(OP_MEASURE, ~p);
		add_request(OP_MEASURE, p);
		// small distances around a mid point: unit, two units, 3-4-5, non-square
		add_request(OP_LOAD, all_coords(64));
		p = all_coords(64);
		p[0] = COORD_WIDTH'(65);
		add_request(OP_MEASURE, p);
		p[9] = COORD_WIDTH'(63);
		add_request(OP_MEASURE, p);
		p = all_coords(64);
		p[3] = COORD_WIDTH'(67);
		p[7] = COORD_WIDTH'(68);
		add_request(OP_MEASURE, p);
		add_request(OP_MEASURE, all_coords(63));
		// back to back loads, only the last one counts
		add_request(OP_LOAD, all_coords(0));
		add_request(OP_LOAD, all_coords(1));
		add_request(OP_MEASURE, all_coords(0));
		add_request(OP_MEASURE, all_coords(COORD_MAX));
		// distinct value in every coordinate
		for (int k = 0; k < NUM_COORD_FIELDS; k++)
			p[k] = COORD_WIDTH'(k * 13);
		add_request(OP_LOAD, p);
		for (int k = 0; k < NUM_COORD_FIELDS; k++)
			p[k] = COORD_WIDTH'(COORD_MAX - k * 13);
		add_request(OP_MEASURE, p);
		add_request(OP_MEASURE, all_coords(0));

		// random part: mostly measures, loads now and then
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			kind = $urandom_range(0, 99);
			style = $urandom_range(0, 3);
			for (int k = 0; k < NUM_COORD_FIELDS; k++)
				p[k] = random_coord(style, int'(generated_reference[k]));
			add_request((kind < 15) ? OP_LOAD : OP_MEASURE, p);
		end

		// drain and finish
		wait (accepted_count == total_items);
		while (distance_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && distance_expected.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// request driver: predicts on acceptance, then offers the next point after its gap
	always @(posedge clk or negedge arst_n) begin
		logic offering;
		point_req_t next_req;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			offering = item_valid && !item_ready;
			if (item_valid && item_ready) begin
				accepted_count++;
				if (offered.op == OP_LOAD)
					reference_copy = offered.coord;
				else
					distance_expected.push_back(predict_distance(offered.coord,
						reference_copy));
			end
			if (!offering) begin
				if (send_gap > 0 || pending_points.size() == 0) begin
					if (send_gap > 0)
						send_gap--;
					item_valid <= 1'b0;
				end else begin
					next_req = pending_points.pop_front();
					offered = next_req;
					sent_count++;
					item_valid <= 1'b1;
					operation <= next_req.op;
					coord_0 <= next_req.coord[0];
					coord_1 <= next_req.coord[1];
					coord_2 <= next_req.coord[2];
					coord_3 <= next_req.coord[3];
					coord_4 <= next_req.coord[4];
					coord_5 <= next_req.coord[5];
					coord_6 <= next_req.coord[6];
					coord_7 <= next_req.coord[7];
					coord_8 <= next_req.coord[8];
					coord_9 <= next_req.coord[9];
					// every fifth stretch of 100 requests goes without gaps
					send_gap = ((sent_count / 100) % 5 == 4) ? 0 : $urandom_range(0, MAX_GAP);
				end
			end
		end
	end

	// result monitor: compares in order and draws a stall before the next result
	always @(posedge clk or negedge arst_n) begin
		distance_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (distance_expected.size() == 0) begin
					report_mismatch("result with nothing pending, squared_distance", -1,
						squared_distance);
				end else begin
					want = distance_expected.pop_front();
					if (squared_distance !== want.sq)
						report_mismatch("squared_distance", want.sq, squared_distance);
					if (distance_fixed !== want.root)
						report_mismatch("distance_fixed", want.root, distance_fixed);
				end
				result_count++;
				recv_gap = ((result_count / 80) % 5 == 2) ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (hold_results) begin
				result_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// long receiver hold-off so the pipeline fills and backs up the input
	initial begin
		wait (accepted_count >= HOLD_START);
		@(posedge clk);
		hold_results <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_results <= 1'b0;
	end

	// watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("simulation failed");
		$finish;
	end

endmodule

### files.f
src/edr_pkg.sv
src/edr_lane.sv
src/edr_root_cell.sv
src/euclidean_distance_to_reference.sv
tb/sv/euclidean_distance_to_reference_test.sv
